// ===== rtl/core/nested_containment_chain_assign_macros.svh =====
// Assertion macros for the nested containment chain assign block.
// Included by the RTL files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef NESTED_CONTAINMENT_CHAIN_ASSIGN_MACROS_SVH
`define NESTED_CONTAINMENT_CHAIN_ASSIGN_MACROS_SVH

`ifndef SYNTHESIS
`define NCCA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NCCA_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define NCCA_ASSERT(lbl, prop, msg)
`define NCCA_NEVER(lbl, expr, msg)
`endif

`endif

// ===== rtl/core/ncca_pkg.sv =====
// Shared types and constants for the nested containment chain assign block.
// Used by the compare unit, the top level and the testbench; no dependencies.
package ncca_pkg;

    localparam int KEY_FIELDS = 3;
    localparam int CHAIN_ID_W = 6;
    localparam int CFG_W      = 2;
    localparam logic [CFG_W-1:0] CFG_RESET = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_TEST,
        ST_WRITE
    } ncca_state_t;

endpackage

// ===== rtl/core/ncca_tail_ram.sv =====
// Chain tail memory: one write port and one read port with registered read data.
// Standalone; contents are undefined until written.
module ncca_tail_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 96,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] tail_mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tail_mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= tail_mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/ncca_dom_cmp.sv =====
// Dominance compare unit: checks that a key is signed greater or equal to a tail
// in each compared column. Depends on ncca_pkg.
module ncca_dom_cmp #(
    parameter int COLS  = 3,
    parameter int KEY_W = 32
) (
    input  logic [COLS*KEY_W-1:0]       key,
    input  logic [COLS*KEY_W-1:0]       tail,
    input  logic [ncca_pkg::CFG_W-1:0]  ncols,
    output logic                        dom
);
    import ncca_pkg::*;

    logic [COLS-1:0] col_ok;

    for (genvar c = 0; c < COLS; c++)
    begin : g_col
        assign col_ok[c] = (CFG_W'(c) >= ncols) ||
                           ($signed(key[c*KEY_W +: KEY_W]) >= $signed(tail[c*KEY_W +: KEY_W]));
    end

    assign dom = &col_ok;

endmodule

// ===== rtl/core/nested_containment_chain_assign.sv =====
// Top level of the nested containment chain assign block.
// Depends on ncca_pkg, ncca_tail_ram, ncca_dom_cmp and the assertion macro header.
//
// Each key item is tested against the open chain tails from chain 0 upward, one chain
// at a time: a tail is read from the tail memory, and in the next cycle the shared
// dominance compare unit checks it. The input is ready again in the cycle
// after the result is loaded. The block takes one item at a time, and the result
// register lets the next item be accepted while a result is still waiting; that item
// then holds before its table write until the output is free. No clearing pass is
// needed after reset.
`include "nested_containment_chain_assign_macros.svh"

module nested_containment_chain_assign #(
    parameter int MAX_CHAINS  = 64,
    parameter int KEY_COLUMNS = 3,
    parameter int KEY_WIDTH   = 32
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           cfg_wr_en,
    input  logic [ncca_pkg::CFG_W-1:0]                     cfg_wr_data,
    input  logic                                           s_tvalid,
    output logic                                           s_tready,
    // key_a, key_b, key_c from the lowest bit up, zero padded to whole bytes
    input  logic [((ncca_pkg::KEY_FIELDS*KEY_WIDTH+7)/8)*8-1:0] s_tdata,
    // start_set
    input  logic [0:0]                                     s_tuser,
    output logic                                           m_tvalid,
    input  logic                                           m_tready,
    // chain_id, zero padded to a byte
    output logic [7:0]                                     m_tdata,
    // opened_chain, overflow
    output logic [1:0]                                     m_tuser
);
    import ncca_pkg::*;

    localparam int STORED  = (KEY_COLUMNS < KEY_FIELDS) ? KEY_COLUMNS : KEY_FIELDS;
    localparam int ENTRY_W = STORED * KEY_WIDTH;
    localparam int AW      = $clog2(MAX_CHAINS);
    localparam int CNT_W   = $clog2(MAX_CHAINS + 1);

    ncca_state_t state_reg, state_next;

    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  found_reg, found_next;
    logic [ENTRY_W-1:0]    key_reg, key_next;
    logic [CFG_W-1:0]      cols_reg;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [CHAIN_ID_W-1:0] out_id_reg;
    logic                  out_opened_reg;
    logic                  out_ovf_reg;

    logic                  rd_en;
    logic                  wr_en;
    logic                  load_out;
    logic [ENTRY_W-1:0]    tail_data;
    logic                  dom;
    logic                  out_free;
    logic                  full;
    logic                  scan_more;
    logic [CNT_W-1:0]      result_id;
    logic [CNT_W+CHAIN_ID_W-1:0] result_ext;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign full      = (count_reg == CNT_W'(MAX_CHAINS));
    assign scan_more = (idx_reg < count_reg);
    assign result_id = (!found_reg && full) ? CNT_W'(MAX_CHAINS - 1) : idx_reg;
    assign result_ext = {{CHAIN_ID_W{1'b0}}, result_id};

    ncca_tail_ram #(
        .DEPTH  (MAX_CHAINS),
        .WIDTH  (ENTRY_W),
        .ADDR_W (AW)
    ) u_tail_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg[AW-1:0]),
        .wr_data (key_reg),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (tail_data)
    );

    ncca_dom_cmp #(
        .COLS  (STORED),
        .KEY_W (KEY_WIDTH)
    ) u_dom_cmp (
        .key   (key_reg),
        .tail  (tail_data),
        .ncols (cols_reg),
        .dom   (dom)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = scan_more ? ST_TEST : ST_WRITE;
            end
            ST_TEST:
            begin
                state_next = dom ? ST_WRITE : ST_FETCH;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_FETCH:
            begin
                rd_en = scan_more;
            end
            ST_TEST:
            begin
            end
            ST_WRITE:
            begin
                load_out = out_free;
                wr_en    = out_free && (found_reg || !full);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        idx_next      = idx_reg;
        count_next    = count_reg;
        found_next    = found_reg;
        key_next      = key_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (s_tvalid && s_tready)
        begin
            key_next   = s_tdata[ENTRY_W-1:0];
            idx_next   = '0;
            found_next = 1'b0;
            if (s_tuser[0])
            begin
                count_next = '0;
            end
        end
        if (state_reg == ST_TEST)
        begin
            if (dom)
            begin
                found_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + CNT_W'(1);
            end
        end
        if (load_out)
        begin
            m_tvalid_next = 1'b1;
            if (!found_reg && !full)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            count_reg    <= '0;
            found_reg    <= 1'b0;
            cols_reg     <= CFG_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            count_reg    <= count_next;
            found_reg    <= found_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en)
            begin
                cols_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (load_out)
        begin
            out_id_reg     <= result_ext[CHAIN_ID_W-1:0];
            out_opened_reg <= !found_reg && !full;
            out_ovf_reg    <= !found_reg && full;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(8 - CHAIN_ID_W){1'b0}}, out_id_reg};
    assign m_tuser  = {out_ovf_reg, out_opened_reg};

    `NCCA_NEVER(a_count_bound, count_reg > CNT_W'(MAX_CHAINS), "Chain count above table size.")
    `NCCA_ASSERT(a_test_in_range, (state_reg == ST_TEST) |-> (idx_reg < count_reg), "Tail test beyond open chains.")
    `NCCA_NEVER(a_flags_exclusive, m_tvalid && m_tuser[0] && m_tuser[1], "Opened and overflow both set.")
    `NCCA_ASSERT(a_start_clears, (s_tvalid && s_tready && s_tuser[0]) |=> (count_reg == '0), "Start item did not clear the table.")

endmodule

// ===== bench/nested_containment_chain_assign_tb.sv =====
// Self-checking testbench for nested_containment_chain_assign: greedy chain assignment
// of key tuples, checked item by item against directed results or a predictor kept in the bench.
// Depends on ncca_pkg and the nested_containment_chain_assign RTL.
`timescale 1ns / 1ps

module nested_containment_chain_assign_tb;

    localparam int CHAINS = 64;
    localparam int KEYS = ncca_pkg::KEY_FIELDS;
    localparam int PHASE_ITEMS = 270;
    localparam int DRAIN_CYCLES = 2 * CHAINS + 12;
    localparam logic [31:0] KMIN = 32'h8000_0000;
    localparam logic [31:0] KMAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [ncca_pkg::CHAIN_ID_W-1:0] chain_id;
        logic opened;
        logic overflow;
    } result_t;

    typedef struct packed {
        logic start;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic typed;
        result_t res;
    } row_t;

    localparam row_t DIRECTED [15] = '{
        '{1'b1, 32'd0, 32'd0, 32'd0, 1'b1, '{6'd0, 1'b1, 1'b0}},
        '{1'b0, 32'd0, 32'd0, 32'd0, 1'b1, '{6'd0, 1'b0, 1'b0}},
        '{1'b0, 32'hFFFF_FFFF, 32'd5, 32'd5, 1'b1, '{6'd1, 1'b1, 1'b0}},
        '{1'b0, KMIN, KMIN, KMIN, 1'b1, '{6'd2, 1'b1, 1'b0}},
        '{1'b0, KMAX, KMAX, KMAX, 1'b1, '{6'd0, 1'b0, 1'b0}},
        '{1'b0, KMIN, KMIN, KMIN, 1'b1, '{6'd2, 1'b0, 1'b0}},
        '{1'b1, KMAX, KMIN, KMAX, 1'b1, '{6'd0, 1'b1, 1'b0}},
        '{1'b0, KMAX, KMAX, KMIN, 1'b1, '{6'd1, 1'b1, 1'b0}},
        '{1'b0, KMAX, KMAX, KMAX, 1'b1, '{6'd0, 1'b0, 1'b0}},
        '{1'b0, 32'd5, 32'hFFFF_FFFB, 32'd7, 1'b0, '0},
        '{1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 1'b0, '0},
        '{1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0, 1'b0, '0},
        '{1'b1, 32'd1, 32'd1, 32'hFFFF_FFFF, 1'b0, '0},
        '{1'b0, 32'd1, 32'd0, 32'd0, 1'b0, '0},
        '{1'b0, 32'h7FFF_FFFE, 32'h8000_0001, 32'd0, 1'b0, '0}
    };

    localparam int PH_CFG [5] = '{3, 0, 1, 2, 3};
    localparam int PH_TX_IDLE [5] = '{0, 70, 0, 21, 0};
    localparam int PH_RX_STALL [5] = '{0, 0, 70, 21, 0};
    localparam int PH_HOLD [5] = '{0, 0, 0, 0, 400};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [ncca_pkg::CFG_W-1:0] cfg_wr_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [95:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;

    logic signed [31:0] chain_tail [CHAINS][KEYS];
    int open_chains = 0;
    int cmp_cols = int'(ncca_pkg::CFG_RESET);

    result_t pending_results [$];
    int errors = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold = 0;

    nested_containment_chain_assign uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #40ms;
        $display("nested_containment_chain_assign_tb NOT OK");
        $finish;
    end

    function automatic result_t assign_chain(input row_t it);
        logic signed [31:0] key [KEYS];
        result_t r;
        logic dom;
        int hit;
        key[0] = $signed(it.a);
        key[1] = $signed(it.b);
        key[2] = $signed(it.c);
        if (it.start)
            open_chains = 0;
        hit = -1;
        for (int j = 0; j < open_chains && hit < 0; j++)
        begin
            dom = 1'b1;
            for (int k = 0; k < cmp_cols && k < KEYS; k++)
                if (key[k] < chain_tail[j][k])
                    dom = 1'b0;
            if (dom)
                hit = j;
        end
        if (hit >= 0)
        begin
            chain_tail[hit] = key;
            r = '{6'(hit), 1'b0, 1'b0};
        end
        else if (open_chains < CHAINS)
        begin
            chain_tail[open_chains] = key;
            r = '{6'(open_chains), 1'b1, 1'b0};
            open_chains++;
        end
        else
            r = '{6'(CHAINS - 1), 1'b0, 1'b1};
        return r;
    endfunction

    function automatic logic [31:0] small_key();
        if ($urandom_range(15) == 0)
            return $urandom_range(1) ? KMAX : KMIN;
        return 32'($urandom_range(12)) - 32'd6;
    endfunction

    // Entered and left just after a falling edge.
    task automatic offer_item(input row_t it);
        result_t predicted;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {it.c, it.b, it.a};
        s_tuser = it.start;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = assign_chain(it);
        pending_results.push_back(it.typed ? it.res : predicted);
        @(negedge clk);
    endtask

    task automatic write_compared_columns(input int value);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = ncca_pkg::CFG_W'(value);
        @(negedge clk);
        cfg_wr_en = 1'b0;
        cmp_cols = value;
    endtask

    task automatic run_group_sequence(inout int sent);
        row_t it;
        int mode;
        int len;
        logic [31:0] drift [KEYS];
        logic [31:0] a_cur;
        mode = $urandom_range(9);
        case (mode)
            7: len = $urandom_range(75, 60);
            8: len = $urandom_range(40, 1);
            9: len = $urandom_range(20, 1);
            default: len = $urandom_range(80, 1);
        endcase
        for (int k = 0; k < KEYS; k++)
            drift[k] = small_key();
        a_cur = $urandom_range(1000000);
        for (int i = 0; i < len && sent < PHASE_ITEMS; i++)
        begin
            it = '0;
            it.start = (i == 0) || ($urandom_range(29) == 0);
            if (mode <= 3)
            begin
                it.a = small_key();
                it.b = small_key();
                it.c = small_key();
            end
            else if (mode <= 6)
            begin
                for (int k = 0; k < KEYS; k++)
                    drift[k] += 32'($urandom_range(3)) - 32'd1;
                it.a = drift[0];
                it.b = drift[1];
                it.c = drift[2];
            end
            else if (mode == 7)
            begin
                // Strictly falling first key: if compared, each item opens a chain until full.
                it.start = (i == 0);
                a_cur -= 32'($urandom_range(1000, 1));
                it.a = a_cur;
                it.b = small_key();
                it.c = small_key();
            end
            else
            begin
                if (mode == 9)
                    it.start = 1'($urandom_range(1));
                it.a = $urandom;
                it.b = $urandom;
                it.c = $urandom;
            end
            offer_item(it);
            sent++;
        end
    endtask

    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_tready = 1'b0;
            rx_hold--;
        end
        else
            m_tready = ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%t: unexpected result chain_id=%0d opened=%b overflow=%b",
                         $realtime, m_tdata[5:0], m_tuser[0], m_tuser[1]);
                errors++;
            end
            else
            begin
                result_t want;
                want = pending_results.pop_front();
                if (m_tdata[5:0] !== want.chain_id)
                begin
                    $display("%t: chain_id expected %0d got %0d",
                             $realtime, want.chain_id, m_tdata[5:0]);
                    errors++;
                end
                if (m_tuser[0] !== want.opened)
                begin
                    $display("%t: opened_chain expected %b got %b",
                             $realtime, want.opened, m_tuser[0]);
                    errors++;
                end
                if (m_tuser[1] !== want.overflow)
                begin
                    $display("%t: overflow expected %b got %b",
                             $realtime, want.overflow, m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int sent;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        foreach (DIRECTED[i])
            offer_item(DIRECTED[i]);
        for (int p = 0; p < 5; p++)
        begin
            write_compared_columns(PH_CFG[p]);
            tx_idle_pct = PH_TX_IDLE[p];
            rx_stall_pct = PH_RX_STALL[p];
            rx_hold = PH_HOLD[p];
            sent = 0;
            while (sent < PHASE_ITEMS)
                run_group_sequence(sent);
        end
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("nested_containment_chain_assign_tb OK");
        else
            $display("nested_containment_chain_assign_tb NOT OK");
        $finish;
    end

endmodule
